>>> hw/rtl/tte_pkg.sv
// Package for the taint table engine: operation, status and state codes.
// No dependencies.
package tte_pkg;
    localparam int TaintDepthDef = 64;
    localparam int KeyDepthDef   = 64;

    typedef enum logic [2:0] {
        OP_QUERY = 3'd0, OP_TAINT = 3'd1, OP_REMOVE = 3'd2, OP_PROP = 3'd3,
        OP_READ = 3'd4, OP_UPD_KEY = 3'd5, OP_UPD_VAL = 3'd6, OP_NOP = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_FULL = 2'd1, ST_NOT_FOUND = 2'd2, ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_TSCAN, S_KSCAN, S_KRD, S_TAINT_WR, S_IDX_RD, S_IDX_DO,
        S_RM_LAST, S_RM_KRD, S_RM_KLAST, S_FIX, S_DONE
    } t_state;
endpackage

>>> hw/rtl/taint_table_engine.sv
// Taint table engine top level: taint and key tables in synchronous memories.
// Depends on tte_pkg.
//
// Usage: one input item on the s_axis channel performs one operation and gives
// exactly one result item on m_axis. Items are taken one at a time; o_s_axis_tready
// is high when the engine is idle, even while a finished result waits on m_axis.
// Work per item, with N live taint entries and K live keys:
//   query / propagate / remove search: one scan of the taint memory, up to N entries;
//   taint scans the key memory instead, up to K keys; read/update is one indexed access;
//   remove with a key freed adds a second taint scan to re-point references.
// Worst case is a remove that frees a key: two taint scans, set by the memory
// scans; each memory has one read port and one write port.
// Reset empties both tables (counts to zero); memory contents are not cleared.
// When the receiver stalls the result is held in the output register; the next
// item is still taken and worked, and its result waits until the register is free.
// s_axis tdata, from bit 0: operation[2:0], address[66:3], source_address[130:67],
//   taint_key[194:131], entry_index[200:195], new_value[264:201], zero pad to 272.
// m_axis tdata, from bit 0: status[1:0], found[2], read_value[66:3],
//   key_position[72:67], entry_count[79:73].
module taint_table_engine
    import tte_pkg::*;
#(
    parameter int TAINT_DEPTH = TaintDepthDef,
    parameter int KEY_DEPTH   = KeyDepthDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [271:0] i_s_axis_tdata,   // op, address, source_address, taint_key, entry_index, new_value
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [79:0]  o_m_axis_tdata    // status, found, read_value, key_position, entry_count
);
    localparam int TW = $clog2(TAINT_DEPTH);
    localparam int KW = $clog2(KEY_DEPTH);
    localparam int CW = TW + 1;
    localparam int KCW = KW + 1;

    logic [63:0] m_taddr [TAINT_DEPTH];
    logic [KW-1:0] m_tkref [TAINT_DEPTH];
    logic [63:0] m_key [KEY_DEPTH];
    logic [CW-1:0] m_kcnt [KEY_DEPTH];

    t_state r_state, n_state;
    logic [CW-1:0] r_tcount, n_tcount;
    logic [KCW-1:0] r_kcount, n_kcount;
    logic [CW-1:0] r_i, n_i;
    logic [2:0] r_op;
    logic [63:0] r_addr, r_src, r_key, r_nval;
    logic [5:0] r_eidx;
    logic [TW-1:0] r_hit, n_hit;
    logic [KW-1:0] r_kref, n_kref;
    logic [KW-1:0] r_last_kref, n_last_kref;
    logic r_ovalid, n_ovalid;
    logic [1:0] r_status, n_status;
    logic r_found, n_found;
    logic [63:0] r_rval, n_rval;
    logic [5:0] r_kpos, n_kpos;
    logic [79:0] r_mdata, n_mdata;

    // memory ports
    logic [TW-1:0] t_ra, t_wa;
    logic t_we;
    logic [63:0] t_wad;
    logic [KW-1:0] t_wkr;
    logic t_wa_addr_en, t_wa_kref_en;
    logic [63:0] t_rd_addr;
    logic [KW-1:0] t_rd_kref;
    logic [KW-1:0] k_ra, k_wa;
    logic k_we_key, k_we_cnt;
    logic [63:0] k_wkey;
    logic [CW-1:0] k_wcnt;
    logic [63:0] k_rd_key;
    logic [CW-1:0] k_rd_cnt;

    always_ff @(posedge i_clk) begin
        if (t_we && t_wa_addr_en) m_taddr[t_wa] <= t_wad;
        if (t_we && t_wa_kref_en) m_tkref[t_wa] <= t_wkr;
        t_rd_addr <= m_taddr[t_ra];
        t_rd_kref <= m_tkref[t_ra];
        if (k_we_key) m_key[k_wa] <= k_wkey;
        if (k_we_cnt) m_kcnt[k_wa] <= k_wcnt;
        k_rd_key <= m_key[k_ra];
        k_rd_cnt <= m_kcnt[k_ra];
    end

    wire accept = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata = r_mdata;

    // scan pipeline: r_i is the index read this cycle; rd_i is the index whose data returns
    wire [CW-1:0] rd_i = r_i - CW'(1);
    wire tscan_live = (r_i != '0) && (rd_i < r_tcount);
    wire [CW-1:0] ksz = CW'(r_kcount);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tcount <= '0;
            r_kcount <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tcount <= n_tcount;
            r_kcount <= n_kcount;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= i_s_axis_tdata[2:0];
            r_addr <= i_s_axis_tdata[66:3];
            r_src <= i_s_axis_tdata[130:67];
            r_key <= i_s_axis_tdata[194:131];
            r_eidx <= i_s_axis_tdata[200:195];
            r_nval <= i_s_axis_tdata[264:201];
        end
        r_i <= n_i;
        r_hit <= n_hit;
        r_kref <= n_kref;
        r_last_kref <= n_last_kref;
        r_status <= n_status;
        r_found <= n_found;
        r_rval <= n_rval;
        r_kpos <= n_kpos;
        r_mdata <= n_mdata;
    end

    always_comb begin
        n_state = r_state;
        n_tcount = r_tcount;
        n_kcount = r_kcount;
        n_i = r_i;
        n_hit = r_hit;
        n_kref = r_kref;
        n_last_kref = r_last_kref;
        n_ovalid = r_ovalid && !i_m_axis_tready;
        n_status = r_status;
        n_found = r_found;
        n_rval = r_rval;
        n_kpos = r_kpos;
        n_mdata = r_mdata;
        t_ra = r_i[TW-1:0];
        t_wa = '0;
        t_we = 1'b0;
        t_wad = '0;
        t_wkr = '0;
        t_wa_addr_en = 1'b0;
        t_wa_kref_en = 1'b0;
        k_ra = r_i[KW-1:0];
        k_wa = '0;
        k_we_key = 1'b0;
        k_we_cnt = 1'b0;
        k_wkey = '0;
        k_wcnt = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = ST_OK;
                    n_found = 1'b0;
                    n_rval = '0;
                    n_kpos = '0;
                    n_i = '0;
                    unique case (t_op'(i_s_axis_tdata[2:0]))
                        OP_QUERY, OP_REMOVE, OP_PROP: n_state = S_TSCAN;
                        OP_TAINT: n_state = S_KSCAN;
                        OP_READ, OP_UPD_KEY, OP_UPD_VAL: n_state = S_IDX_RD;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_TSCAN: begin
                // read index r_i, compare data of r_i-1
                t_ra = r_i[TW-1:0];
                n_i = r_i + CW'(1);
                if (tscan_live && t_rd_addr == ((r_op == OP_PROP) ? r_src : r_addr)) begin
                    n_hit = rd_i[TW-1:0];
                    n_kref = t_rd_kref;
                    if (r_op == OP_QUERY) begin
                        n_found = 1'b1;
                        n_state = S_DONE;
                    end else if (r_op == OP_PROP) begin
                        if (r_tcount >= CW'(TAINT_DEPTH)) begin
                            n_status = ST_FULL;
                            n_state = S_DONE;
                        end else begin
                            k_ra = t_rd_kref;
                            n_state = S_KRD;
                        end
                    end else begin
                        t_ra = TW'(r_tcount - CW'(1));
                        n_state = S_RM_LAST;
                    end
                end else if (r_i != '0 && rd_i >= r_tcount) begin
                    if (r_op != OP_QUERY) n_status = ST_NOT_FOUND;
                    n_state = S_DONE;
                end
            end
            S_KRD: begin
                // propagate: bump refcount, append entry
                if (CW'(r_kref) < ksz) begin
                    k_wa = r_kref;
                    k_we_cnt = 1'b1;
                    k_wcnt = k_rd_cnt + CW'(1);
                end
                t_we = 1'b1;
                t_wa_addr_en = 1'b1;
                t_wa_kref_en = 1'b1;
                t_wa = r_tcount[TW-1:0];
                t_wad = r_addr;
                t_wkr = r_kref;
                n_tcount = r_tcount + CW'(1);
                n_kpos = 6'(r_kref);
                n_state = S_DONE;
            end
            S_KSCAN: begin
                k_ra = r_i[KW-1:0];
                n_i = r_i + CW'(1);
                if (r_i != '0 && rd_i < ksz && k_rd_key == r_key) begin
                    n_kref = rd_i[KW-1:0];
                    n_state = (r_tcount >= CW'(TAINT_DEPTH)) ? S_DONE : S_TAINT_WR;
                    if (r_tcount >= CW'(TAINT_DEPTH)) n_status = ST_FULL;
                    n_hit = '1;
                end else if (r_i != '0 && rd_i >= ksz) begin
                    n_kref = rd_i[KW-1:0];
                    n_hit = '0;
                    if (r_tcount >= CW'(TAINT_DEPTH) || r_kcount >= KCW'(KEY_DEPTH)) begin
                        n_status = ST_FULL;
                        n_state = S_DONE;
                    end else n_state = S_TAINT_WR;
                end
                if (n_state == S_TAINT_WR) begin
                    k_ra = n_kref;
                    n_state = S_KRD;
                    n_rval = '0;
                    n_found = 1'b0;
                    // r_hit all ones marks an existing key
                    n_state = S_TAINT_WR;
                end
            end
            S_TAINT_WR: begin
                k_wa = r_kref;
                k_we_cnt = 1'b1;
                if (r_hit == '0) begin
                    k_we_key = 1'b1;
                    k_wkey = r_key;
                    k_wcnt = CW'(1);
                    n_kcount = r_kcount + KCW'(1);
                end else k_wcnt = k_rd_cnt + CW'(1);
                t_we = 1'b1;
                t_wa_addr_en = 1'b1;
                t_wa_kref_en = 1'b1;
                t_wa = r_tcount[TW-1:0];
                t_wad = r_addr;
                t_wkr = r_kref;
                n_tcount = r_tcount + CW'(1);
                n_kpos = 6'(r_kref);
                n_state = S_DONE;
            end
            S_IDX_RD: begin
                t_ra = r_eidx[TW-1:0];
                if (CW'(r_eidx) >= r_tcount) begin
                    n_status = ST_RANGE;
                    n_state = S_DONE;
                end else n_state = S_IDX_DO;
            end
            S_IDX_DO: begin
                if (r_op == OP_READ) n_rval = t_rd_addr;
                else if (r_op == OP_UPD_VAL) begin
                    t_we = 1'b1;
                    t_wa_addr_en = 1'b1;
                    t_wa = r_eidx[TW-1:0];
                    t_wad = r_nval;
                end else if (CW'(t_rd_kref) < ksz) begin
                    k_wa = t_rd_kref;
                    k_we_key = 1'b1;
                    k_wkey = r_nval;
                end
                n_state = S_DONE;
            end
            S_RM_LAST: begin
                // last entry data arrives; move it into the hole
                t_we = 1'b1;
                t_wa_addr_en = 1'b1;
                t_wa_kref_en = 1'b1;
                t_wa = r_hit;
                t_wad = t_rd_addr;
                t_wkr = t_rd_kref;
                n_tcount = r_tcount - CW'(1);
                k_ra = r_kref;
                n_state = (CW'(r_kref) < ksz) ? S_RM_KRD : S_DONE;
            end
            S_RM_KRD: begin
                k_wa = r_kref;
                k_we_cnt = 1'b1;
                k_wcnt = (k_rd_cnt != '0) ? k_rd_cnt - CW'(1) : '0;
                if (k_wcnt == '0) begin
                    k_we_cnt = 1'b0;
                    k_ra = KW'(r_kcount - KCW'(1));
                    n_state = S_RM_KLAST;
                end else n_state = S_DONE;
            end
            S_RM_KLAST: begin
                k_wa = r_kref;
                k_we_key = 1'b1;
                k_we_cnt = 1'b1;
                k_wkey = k_rd_key;
                k_wcnt = k_rd_cnt;
                n_last_kref = KW'(r_kcount - KCW'(1));
                n_kcount = r_kcount - KCW'(1);
                n_i = '0;
                n_state = S_FIX;
            end
            S_FIX: begin
                // re-point entries that held the old last key index
                t_ra = r_i[TW-1:0];
                n_i = r_i + CW'(1);
                if (tscan_live && t_rd_kref == r_last_kref) begin
                    t_we = 1'b1;
                    t_wa_kref_en = 1'b1;
                    t_wa = rd_i[TW-1:0];
                    t_wkr = r_kref;
                end
                if (r_i != '0 && rd_i >= r_tcount) n_state = S_DONE;
            end
            S_DONE: begin
                // hold the result here until the output register is free
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_mdata = {7'(r_tcount), r_kpos, r_rval, r_found, r_status};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // A read in the same cycle as a write in S_FIX touches a different index.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tcount <= CW'(TAINT_DEPTH)) else $error("taint count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kcount <= KCW'(KEY_DEPTH)) else $error("key count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_ovalid || i_m_axis_tready)) |=> r_ovalid)
        else $error("finished result not presented");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("stalled result changed");
endmodule
